/* rtl/vpdd_pkg.sv */
package vpdd_pkg;

    // vote window and derived widths
    localparam int VOTE_WINDOW = 7;
    localparam int VOTE_CNT_W  = $clog2(VOTE_WINDOW + 1);

    // field and register widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 7;
    localparam int DIR_W    = 2;
    localparam int EVENT_W  = 8;
    localparam int QUIET_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [EVENT_W-1:0] EVENT_MAX = '1;
    localparam logic [QUIET_W-1:0] QUIET_MAX = '1;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_IDLE  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_OPEN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_CLOSE = 2'd2;

    // curtain positions
    localparam logic [POS_W-1:0] POS_CLOSED = 7'd0;
    localparam logic [POS_W-1:0] POS_OPEN   = 7'd100;
    localparam logic [POS_W-1:0] TARGET_OPEN  = 7'd0;
    localparam logic [POS_W-1:0] TARGET_CLOSE = 7'd100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_QUIET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EVENTS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_QUIET     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_QUIET    = 3'd6;

    // register reset values
    localparam logic signed [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 16'sd100;
    localparam logic signed [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = -16'sd100;
    localparam logic [QUIET_W-1:0] SETTLE_QUIET_RST = 10'd20;
    localparam logic [EVENT_W-1:0] MIN_EVENTS_RST   = 8'd20;
    localparam logic [QUIET_W-1:0] FIRE_QUIET_RST   = 10'd100;
    localparam logic [QUIET_W-1:0] STALE_QUIET_RST  = 10'd500;

    typedef logic [DIR_W-1:0] t_dir;

endpackage

/* rtl/vibration_push_direction_detector.sv */
// Push-to-move detector: one accelerometer sample per item, with the motor-idle flag and
// the curtain position, gives one result item (fire, target, pending direction). The whole
// update of the event and quiet counters, the seven-slot sign vote and the fire and stale
// checks is one combinational pass from the accepted item and the state registers into an
// output register, so an item is taken every cycle and its result shows in the cycle after;
// the only stall comes from a full output register that the downstream side holds off.
// Configuration writes take effect at once and belong in idle periods only.
module vibration_push_direction_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vpdd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vpdd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [vpdd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_motor_idle,
    input  logic [vpdd_pkg::POS_W-1:0]          i_position_percent,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_fire,
    output logic [vpdd_pkg::POS_W-1:0]          o_target_percent,
    output logic [vpdd_pkg::DIR_W-1:0]          o_pending_direction
);
    import vpdd_pkg::*;

    // configuration
    logic                       r_auto_enable;
    logic signed [SAMPLE_W-1:0] r_high_threshold;
    logic signed [SAMPLE_W-1:0] r_low_threshold;
    logic [QUIET_W-1:0]         r_settle_quiet;
    logic [EVENT_W-1:0]         r_min_events;
    logic [QUIET_W-1:0]         r_fire_quiet;
    logic [QUIET_W-1:0]         r_stale_quiet;

    // detector state
    logic [VOTE_WINDOW-1:0] r_votes;
    logic [VOTE_WINDOW-1:0] n_votes;
    logic [EVENT_W-1:0]     r_event_count;
    logic [EVENT_W-1:0]     n_event_count;
    logic [QUIET_W-1:0]     r_quiet_count;
    logic [QUIET_W-1:0]     n_quiet_count;
    t_dir                   r_pending;
    t_dir                   n_pending;

    // output register
    logic             r_out_valid;
    logic             r_fire;
    logic [POS_W-1:0] r_target;
    t_dir             r_pending_out;
    logic             n_fire;
    logic [POS_W-1:0] n_target;

    logic                  in_accept;
    logic                  active;
    logic                  is_event;
    logic [EVENT_W-1:0]    ev_cnt1;
    logic [QUIET_W-1:0]    qt_cnt1;
    logic [VOTE_CNT_W-1:0] closes;
    logic                  decide;
    t_dir                  decision;
    t_dir                  pend2;
    logic [QUIET_W-1:0]    qt_cnt2;
    logic [EVENT_W-1:0]    ev_cnt2;
    logic                  fire_now;
    t_dir                  pend3;
    logic [QUIET_W-1:0]    qt_cnt3;

    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;
    assign active    = r_auto_enable & i_motor_idle;

    always_comb begin
        is_event = (i_sample > r_high_threshold) || (i_sample < r_low_threshold);

        // store the sign only while vote slots remain
        for (int i = 0; i < VOTE_WINDOW; i++) begin
            if (is_event && (r_event_count == EVENT_W'(i))) begin
                n_votes[i] = i_sample[SAMPLE_W-1];
            end else begin
                n_votes[i] = r_votes[i];
            end
        end

        if (is_event) begin
            ev_cnt1 = (r_event_count != EVENT_MAX) ? r_event_count + 1'b1 : r_event_count;
            qt_cnt1 = '0;
        end else begin
            ev_cnt1 = r_event_count;
            qt_cnt1 = (r_quiet_count != QUIET_MAX) ? r_quiet_count + 1'b1 : r_quiet_count;
        end

        closes = VOTE_CNT_W'($countones(n_votes));
        decide = (qt_cnt1 > r_settle_quiet) && (ev_cnt1 >= r_min_events);

        // fully closed or fully open overrides the vote
        priority if (i_position_percent == POS_CLOSED) begin
            decision = DIR_CLOSE;
        end else if (i_position_percent == POS_OPEN) begin
            decision = DIR_OPEN;
        end else if ({closes, 1'b0} > (VOTE_CNT_W + 1)'(VOTE_WINDOW)) begin
            decision = DIR_CLOSE;
        end else begin
            decision = DIR_OPEN;
        end

        pend2   = decide ? decision : r_pending;
        qt_cnt2 = decide ? '0 : qt_cnt1;
        ev_cnt2 = decide ? '0 : ev_cnt1;

        fire_now = (pend2 != DIR_IDLE) && (qt_cnt2 >= r_fire_quiet);
        pend3    = fire_now ? DIR_IDLE : pend2;
        qt_cnt3  = fire_now ? '0 : qt_cnt2;

        if (active) begin
            n_fire   = fire_now;
            n_target = !fire_now ? TARGET_OPEN
                     : (pend2 == DIR_OPEN) ? TARGET_OPEN : TARGET_CLOSE;
            n_pending = pend3;
            if (qt_cnt3 > r_stale_quiet) begin
                n_quiet_count = '0;
                n_event_count = '0;
            end else begin
                n_quiet_count = qt_cnt3;
                n_event_count = ev_cnt2;
            end
        end else begin
            n_fire        = 1'b0;
            n_target      = TARGET_OPEN;
            n_pending     = r_pending;
            n_quiet_count = r_quiet_count;
            n_event_count = r_event_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_enable    <= 1'b0;
            r_high_threshold <= HIGH_THRESHOLD_RST;
            r_low_threshold  <= LOW_THRESHOLD_RST;
            r_settle_quiet   <= SETTLE_QUIET_RST;
            r_min_events     <= MIN_EVENTS_RST;
            r_fire_quiet     <= FIRE_QUIET_RST;
            r_stale_quiet    <= STALE_QUIET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_AUTO_ENABLE:    r_auto_enable    <= i_cfg_data[0];
                REG_HIGH_THRESHOLD: r_high_threshold <= i_cfg_data[SAMPLE_W-1:0];
                REG_LOW_THRESHOLD:  r_low_threshold  <= i_cfg_data[SAMPLE_W-1:0];
                REG_SETTLE_QUIET:   r_settle_quiet   <= i_cfg_data[QUIET_W-1:0];
                REG_MIN_EVENTS:     r_min_events     <= i_cfg_data[EVENT_W-1:0];
                REG_FIRE_QUIET:     r_fire_quiet     <= i_cfg_data[QUIET_W-1:0];
                REG_STALE_QUIET:    r_stale_quiet    <= i_cfg_data[QUIET_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_count <= '0;
            r_quiet_count <= '0;
            r_pending     <= DIR_IDLE;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_event_count <= n_event_count;
                r_quiet_count <= n_quiet_count;
                r_pending     <= n_pending;
                r_out_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // vote slots and result payload carry no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (active) begin
                r_votes <= n_votes;
            end
            r_fire        <= n_fire;
            r_target      <= n_target;
            r_pending_out <= n_pending;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_fire              = r_fire;
    assign o_target_percent    = r_target;
    assign o_pending_direction = r_pending_out;

endmodule
